### sv/timed_trajectory_tracker_macros.svh
// Assertion macros shared by the trajectory tracker RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TIMED_TRAJECTORY_TRACKER_MACROS_SVH
`define TIMED_TRAJECTORY_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define TTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ttt_pkg.sv
// Types and constants of the trajectory tracker.
// No dependencies; used by ttt_mod_unit and timed_trajectory_tracker.
package ttt_pkg;

	// input transaction
	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        pos_yaw;
		logic [31:0]        elapsed_time;
		logic signed [31:0] wp_x;
		logic signed [31:0] wp_y;
		logic [31:0]        wp_time;
		logic signed [15:0] wp_speed;
		logic signed [15:0] wp_yawrate;
		logic [15:0]        wp_yaw;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic [15:0]        speed_cmd;
		logic signed [15:0] yawrate_cmd;
		logic [7:0]         target_index;
		logic [1:0]         status;
	} res_t;

	// one waypoint as stored in the table memory
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        wtime;
		logic signed [15:0] speed;
		logic signed [15:0] yawrate;
		logic [15:0]        heading;
	} entry_t;

	// modulo unit request and response
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} div_resp_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_ZERO_PERIOD
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PERIOD_RD,
		ST_PERIOD_CHK,
		ST_DIVIDE,
		ST_SEARCH,
		ST_SINE,
		ST_PRODUCT,
		ST_FINISH
	} state_t;

	localparam logic [1:0] CMD_APPEND   = 2'd0;
	localparam logic [1:0] CMD_POSITION = 2'd1;
	localparam logic [1:0] CMD_CONTROL  = 2'd2;

	localparam logic REG_LONG_GAIN = 1'b0;
	localparam logic REG_LAT_GAIN  = 1'b1;

	localparam logic [15:0] LONG_GAIN_RESET = 16'd655;
	localparam logic [15:0] LAT_GAIN_RESET  = 16'd3277;

	// 20 ms in Q16.16
	localparam logic signed [33:0] WINDOW_Q16  = 34'sd1311;
	localparam logic signed [71:0] SPEED_MAX   = 72'sd40960;
	localparam logic signed [71:0] YAWRATE_LIM = 72'sd16384;
	localparam logic signed [71:0] ONE_Q30     = 72'sd1073741824;

	// odd quarter-wave sine polynomial coefficients, Q2.30
	function automatic logic signed [35:0] poly_coef(input logic [2:0] k);
		case (k)
			3'd0: return 36'sd1686629713;
			3'd1: return 36'sd693598668;
			3'd2: return 36'sd85569306;
			3'd3: return 36'sd5026995;
			3'd4: return 36'sd172272;
			default: return 36'sd0;
		endcase
	endfunction

endpackage

### sv/timed_trajectory_tracker.sv
// Trajectory tracker top level: waypoint table memory, control sequencer,
// shared multiplier. Depends on ttt_pkg, ttt_mod_unit and the macro header.
//
// Usage:
//   cmd/cmd_valid/cmd_stall carry input transactions; res/res_valid/res_stall
//   carry results. A transaction moves on a clock edge with valid high and
//   stall low. cfg_we/cfg_index/cfg_data write long_gain (0) and lat_gain (1).
//   Append (0) and position (1) give no result; code 3 is dropped. A control
//   step (2) gives one result; its duration is set by the bit-serial modulo,
//   the table search that reads one entry per cycle from the single read
//   port up to the index n that it chooses, and the shared multiplier: four
//   sine polynomials of six products and seven error products. One control
//   step is worked on at a time; cmd_stall stays high until its result is in
//   the output register. An empty table or a zero period returns a status
//   without the modulo and the search. Reset empties the table, clears the
//   stored position and restores gains. While res_stall is high the result
//   holds; a following step waits in its finish state until the output
//   register is free.
`include "timed_trajectory_tracker_macros.svh"

module timed_trajectory_tracker #(
	parameter int MAX_WAYPOINTS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  ttt_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output ttt_pkg::res_t  res,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data
);
	import ttt_pkg::*;

	localparam int IW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);

	// sine or cosine from quarter-wave values and the quadrant
	function automatic logic signed [31:0] trig_pick(input logic [1:0] quad,
		input logic [30:0] ps, input logic [30:0] pc, input logic want_cos);
		logic signed [31:0] sp;
		logic signed [31:0] cp;
		logic signed [31:0] s;
		logic signed [31:0] c;
		sp = $signed({1'b0, ps});
		cp = $signed({1'b0, pc});
		case (quad)
			2'd0: begin s = sp;  c = cp;  end
			2'd1: begin s = cp;  c = -sp; end
			2'd2: begin s = -sp; c = -cp; end
			default: begin s = -cp; c = sp; end
		endcase
		return want_cos ? c : s;
	endfunction

	state_t state_q, state_d;

	entry_t             mem [MAX_WAYPOINTS];
	entry_t             rd_data_q;
	logic [IW-1:0]      rd_addr;
	logic               mem_we;
	entry_t             wr_data;

	logic [CW-1:0]      count_q;
	logic [IW-1:0]      last_idx;
	logic signed [31:0] stored_x_q, stored_y_q;
	logic [15:0]        long_gain_q, lat_gain_q;

	logic               cmd_accept;
	logic [15:0]        yaw_q;
	logic [31:0]        elapsed_q;
	logic [31:0]        folded_q;

	div_req_t           div_req;
	div_resp_t          div_resp;

	logic [CW-1:0]      ptr_q;
	logic               issue;
	logic               chk_valid_s1;
	logic [IW-1:0]      chk_idx_s1;
	logic signed [33:0] diff;
	logic               found;

	logic [IW-1:0]      idx_q;
	logic signed [15:0] speed_q, yawrate_q;
	logic [15:0]        heading_q;
	logic signed [32:0] dx_q, dy_q;

	logic               phase_q;
	logic [2:0]         h_q;
	logic [1:0]         qsel_q;
	logic [2:0]         op_q;
	logic [30:0]        qs_q [4];
	logic signed [35:0] z2_q, p_q;
	logic [15:0]        rel_yaw;
	logic [13:0]        frac;
	logic [14:0]        u;
	logic [30:0]        z;

	logic signed [35:0] mul_a, mul_b;
	logic signed [71:0] prod_q;
	logic signed [71:0] acc_q;
	logic signed [71:0] shifted, spd_sh, yr_sh;
	logic signed [35:0] lat_q, lon_q;
	logic signed [31:0] sin_h, cos_h, cos_rel;

	logic [15:0]        spd_q;
	logic signed [15:0] yr_q;
	status_t            status_q;
	res_t               res_q;
	logic               res_valid_q;
	logic               res_load;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign last_idx   = IW'(count_q - 1'b1);
	assign res_load   = (state_q == ST_FINISH) && (!res_valid_q || !res_stall);

	// table memory: one write port, one registered read port
	assign mem_we = cmd_accept && (cmd.command == CMD_APPEND) &&
		(count_q < CW'(MAX_WAYPOINTS));
	assign wr_data = '{x: cmd.wp_x, y: cmd.wp_y, wtime: cmd.wp_time,
		speed: cmd.wp_speed, yawrate: cmd.wp_yawrate, heading: cmd.wp_yaw};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IW-1:0]] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	ttt_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// search compare on the entry read last cycle
	assign issue = (ptr_q < count_q);
	assign diff  = $signed({2'b00, folded_q}) - $signed({2'b00, rd_data_q.wtime});
	assign found = chk_valid_s1 && ((diff <= WINDOW_Q16) || (chk_idx_s1 == last_idx));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read address, modulo start
	always_comb begin
		state_d          = state_q;
		rd_addr          = ptr_q[IW-1:0];
		div_req.start    = 1'b0;
		div_req.dividend = elapsed_q;
		div_req.divisor  = rd_data_q.wtime;
		case (state_q)
			ST_IDLE: begin
				if (cmd_accept && cmd.command == CMD_CONTROL) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_PERIOD_RD;
				end
			end
			ST_PERIOD_RD: begin
				rd_addr = last_idx;
				state_d = ST_PERIOD_CHK;
			end
			ST_PERIOD_CHK: begin
				if (rd_data_q.wtime == '0) begin
					state_d = ST_FINISH;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_resp.done) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (found) state_d = ST_SINE;
			end
			ST_SINE: begin
				if (phase_q && h_q == 3'd5 && qsel_q == 2'd3) state_d = ST_PRODUCT;
			end
			ST_PRODUCT: begin
				if (phase_q && op_q == 3'd6) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (res_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// polynomial argument: z = u quarter-turn fraction in Q2.30
	assign rel_yaw = heading_q - yaw_q;
	assign frac    = qsel_q[1] ? rel_yaw[13:0] : yaw_q[13:0];
	assign u       = qsel_q[0] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
	assign z       = {u, 16'd0};

	assign sin_h   = trig_pick(yaw_q[15:14], qs_q[0], qs_q[1], 1'b0);
	assign cos_h   = trig_pick(yaw_q[15:14], qs_q[0], qs_q[1], 1'b1);
	assign cos_rel = trig_pick(rel_yaw[15:14], qs_q[2], qs_q[3], 1'b1);

	// shared multiplier operand select
	always_comb begin
		mul_a = 36'(z);
		mul_b = 36'(z);
		if (state_q == ST_SINE) begin
			case (h_q)
				3'd0: begin mul_a = 36'(z); mul_b = 36'(z); end
				3'd5: begin mul_a = 36'(z); mul_b = p_q; end
				default: begin mul_a = z2_q; mul_b = p_q; end
			endcase
		end else begin
			case (op_q)
				3'd0: begin mul_a = 36'(dx_q); mul_b = 36'(sin_h); end
				3'd1: begin mul_a = 36'(dy_q); mul_b = 36'(cos_h); end
				3'd2: begin mul_a = 36'(dx_q); mul_b = 36'(cos_h); end
				3'd3: begin mul_a = 36'(dy_q); mul_b = 36'(sin_h); end
				3'd4: begin mul_a = 36'(speed_q); mul_b = 36'(cos_rel); end
				3'd5: begin mul_a = 36'({1'b0, long_gain_q}); mul_b = lon_q; end
				default: begin mul_a = 36'({1'b0, lat_gain_q}); mul_b = lat_q; end
			endcase
		end
	end

	// writeback arithmetic
	assign shifted = prod_q >>> 30;
	assign spd_sh  = (acc_q + (prod_q <<< 6)) >>> 26;
	assign yr_sh   = ((72'(yawrate_q) <<< 20) - prod_q) >>> 18;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			stored_x_q   <= '0;
			stored_y_q   <= '0;
			long_gain_q  <= LONG_GAIN_RESET;
			lat_gain_q   <= LAT_GAIN_RESET;
			ptr_q        <= '0;
			chk_valid_s1 <= 1'b0;
			phase_q      <= 1'b0;
			h_q          <= '0;
			qsel_q       <= '0;
			op_q         <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LONG_GAIN: long_gain_q <= cfg_data;
					default:       lat_gain_q  <= cfg_data;
				endcase
			end
			if (mem_we) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd_accept && cmd.command == CMD_POSITION) begin
				stored_x_q <= cmd.pos_x;
				stored_y_q <= cmd.pos_y;
			end
			case (state_q)
				ST_PERIOD_CHK: begin
					ptr_q        <= '0;
					chk_valid_s1 <= 1'b0;
				end
				ST_SEARCH: begin
					ptr_q        <= ptr_q + CW'(issue);
					chk_valid_s1 <= issue && !found;
					if (found) begin
						phase_q <= 1'b0;
						h_q     <= '0;
						qsel_q  <= '0;
						op_q    <= '0;
					end
				end
				ST_SINE: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (h_q == 3'd5) begin
							h_q    <= '0;
							qsel_q <= qsel_q + 2'd1;
						end else begin
							h_q <= h_q + 3'd1;
						end
					end
				end
				ST_PRODUCT: begin
					phase_q <= !phase_q;
					if (phase_q) op_q <= op_q + 3'd1;
				end
				default: begin
				end
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (cmd_accept && cmd.command == CMD_CONTROL) begin
					yaw_q     <= cmd.pos_yaw;
					elapsed_q <= cmd.elapsed_time;
					status_q  <= STATUS_EMPTY;
					spd_q     <= '0;
					yr_q      <= '0;
					idx_q     <= '0;
				end
			end
			ST_PERIOD_CHK: begin
				status_q <= STATUS_ZERO_PERIOD;
			end
			ST_DIVIDE: begin
				if (div_resp.done) folded_q <= div_resp.rem;
			end
			ST_SEARCH: begin
				chk_idx_s1 <= ptr_q[IW-1:0];
				if (found) begin
					idx_q     <= chk_idx_s1;
					speed_q   <= rd_data_q.speed;
					yawrate_q <= rd_data_q.yawrate;
					heading_q <= rd_data_q.heading;
					dx_q      <= 33'(rd_data_q.x) - 33'(stored_x_q);
					dy_q      <= 33'(rd_data_q.y) - 33'(stored_y_q);
				end
			end
			ST_SINE: begin
				if (phase_q) begin
					case (h_q)
						3'd0: begin
							z2_q <= 36'(shifted);
							p_q  <= poly_coef(3'd4);
						end
						3'd5: begin
							qs_q[qsel_q] <= (shifted > ONE_Q30) ? 31'(ONE_Q30) : 31'(shifted);
						end
						default: begin
							p_q <= poly_coef(3'd4 - h_q) - 36'(shifted);
						end
					endcase
				end
			end
			ST_PRODUCT: begin
				if (phase_q) begin
					case (op_q)
						3'd1: lat_q <= 36'((acc_q - prod_q) >>> 30);
						3'd3: lon_q <= 36'((acc_q + prod_q) >>> 30);
						3'd5: begin
							if (spd_sh < 0) spd_q <= '0;
							else if (spd_sh > SPEED_MAX) spd_q <= 16'(SPEED_MAX);
							else spd_q <= spd_sh[15:0];
						end
						3'd6: begin
							status_q <= STATUS_OK;
							if (yr_sh < -YAWRATE_LIM) yr_q <= 16'(-YAWRATE_LIM);
							else if (yr_sh > YAWRATE_LIM) yr_q <= 16'(YAWRATE_LIM);
							else yr_q <= yr_sh[15:0];
						end
						default: acc_q <= prod_q;
					endcase
				end
			end
			ST_FINISH: begin
				if (res_load) begin
					res_q.speed_cmd    <= spd_q;
					res_q.yawrate_cmd  <= yr_q;
					res_q.target_index <= 8'(idx_q);
					res_q.status       <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	`TTT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_WAYPOINTS), "entry count over capacity")
	`TTT_ASSERT_NEXT(a_empty_step, cmd_accept && cmd.command == CMD_CONTROL && count_q == '0, state_q == ST_FINISH, "empty table step did not finish at once")
	`TTT_ASSERT_IMP(a_found_range, state_q == ST_SEARCH && found, CW'(chk_idx_s1) < count_q, "target beyond table fill")
	`TTT_ASSERT_IMP(a_result_src, $rose(res_valid_q), $past(state_q == ST_FINISH), "result loaded outside finish")

endmodule

### sv/ttt_mod_unit.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on ttt_pkg for the request and response structs.
module ttt_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  ttt_pkg::div_req_t   req,
	output ttt_pkg::div_resp_t  resp
);
	import ttt_pkg::*;

	logic [32:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] trial;

	// shift in next dividend bit
	assign trial = {rem_q[31:0], dvd_q[31]};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign resp.done = done_q;
	assign resp.rem  = rem_q[31:0];

endmodule

### dv/timed_trajectory_tracker_tb.sv
// Testbench of the trajectory tracker: directed and random waypoint, position
// and control-step transactions, checked against an in-bench fixed-point model.
// Depends on ttt_pkg and the timed_trajectory_tracker RTL.
module timed_trajectory_tracker_tb;
	import ttt_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int EXP_DEPTH = 64;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// expected steering commands, oldest first
	class steer_scoreboard;
		res_t exp_buf[EXP_DEPTH];
		int wr_ptr, rd_ptr;
		int errors;
		logic signed [31:0] wx[TABLE_DEPTH];
		logic signed [31:0] wy[TABLE_DEPTH];
		logic [31:0] wt[TABLE_DEPTH];
		logic signed [15:0] wv[TABLE_DEPTH];
		logic signed [15:0] wr[TABLE_DEPTH];
		logic [15:0] wh[TABLE_DEPTH];
		int count;
		logic signed [31:0] veh_x, veh_y;
		logic [15:0] k_long, k_lat;

		function new();
			count = 0; veh_x = 0; veh_y = 0; errors = 0;
			wr_ptr = 0; rd_ptr = 0;
			k_long = LONG_GAIN_RESET; k_lat = LAT_GAIN_RESET;
		endfunction

		// results still owed by the block
		function int outstanding();
			return wr_ptr - rd_ptr;
		endfunction

		function longint floor_sh(longint v, int n);
			return v >>> n;
		endfunction

		function longint qsine(longint u);
			longint z, z2, p;
			longint c[5];
			c[0] = 1686629713; c[1] = 693598668; c[2] = 85569306;
			c[3] = 5026995; c[4] = 172272;
			z = u << 16;
			z2 = (z * z) >>> 30;
			p = c[4];
			for (int k = 3; k >= 0; k--)
				p = c[k] - ((z2 * p) >>> 30);
			p = (z * p) >>> 30;
			return (p > 64'sd1073741824) ? 64'sd1073741824 : p;
		endfunction

		task sincos(input logic [15:0] a, output longint s, output longint c);
			longint ps, pc;
			ps = qsine(a[13:0]);
			pc = qsine(16384 - a[13:0]);
			case (a[15:14])
				2'd0: begin s = ps; c = pc; end
				2'd1: begin s = pc; c = -ps; end
				2'd2: begin s = -ps; c = -pc; end
				default: begin s = -pc; c = ps; end
			endcase
		endtask

		// note one accepted input transaction
		task note_input(cmd_t t);
			res_t r;
			longint period, folded, dx, dy, s, c, vs, vc, lat, lon, acc, spd, yr;
			int idx;
			case (t.command)
				CMD_APPEND: begin
					if (count < TABLE_DEPTH) begin
						wx[count] = t.wp_x; wy[count] = t.wp_y; wt[count] = t.wp_time;
						wv[count] = t.wp_speed; wr[count] = t.wp_yawrate;
						wh[count] = t.wp_yaw;
						count++;
					end
				end
				CMD_POSITION: begin
					veh_x = t.pos_x; veh_y = t.pos_y;
				end
				CMD_CONTROL: begin
					r = '0;
					if (count == 0) r.status = STATUS_EMPTY;
					else if (wt[count-1] == 0) r.status = STATUS_ZERO_PERIOD;
					else begin
						period = wt[count-1];
						folded = longint'(t.elapsed_time) % period;
						idx = count - 1;
						for (int i = 0; i < count; i++)
							if (folded - longint'(wt[i]) <= 1311) begin
								idx = i;
								break;
							end
						dx = longint'(wx[idx]) - longint'(veh_x);
						dy = longint'(wy[idx]) - longint'(veh_y);
						sincos(t.pos_yaw, s, c);
						lat = floor_sh(dx * s - dy * c, 30);
						lon = floor_sh(dx * c + dy * s, 30);
						sincos(wh[idx] - t.pos_yaw, vs, vc);
						acc = longint'(wv[idx]) * vc + longint'(k_long) * lon * 64;
						spd = floor_sh(acc, 26);
						if (spd < 0) spd = 0;
						if (spd > 40960) spd = 40960;
						acc = longint'(wr[idx]) * 1048576 - longint'(k_lat) * lat;
						yr = floor_sh(acc, 18);
						if (yr < -16384) yr = -16384;
						if (yr > 16384) yr = 16384;
						r.speed_cmd = spd[15:0];
						r.yawrate_cmd = yr[15:0];
						r.target_index = idx[7:0];
						r.status = STATUS_OK;
					end
					exp_buf[wr_ptr % EXP_DEPTH] = r;
					wr_ptr++;
				end
				default: ;
			endcase
		endtask

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		// check one accepted result against the oldest expectation
		task check_result(res_t got);
			res_t e;
			if (outstanding() == 0) begin
				report("unexpected result", 32'(got.status), 32'd0);
				return;
			end
			e = exp_buf[rd_ptr % EXP_DEPTH];
			rd_ptr++;
			if (got.speed_cmd !== e.speed_cmd)
				report("speed_cmd", 32'(got.speed_cmd), 32'(e.speed_cmd));
			if (got.yawrate_cmd !== e.yawrate_cmd)
				report("yawrate_cmd", 32'(got.yawrate_cmd), 32'(e.yawrate_cmd));
			if (got.target_index !== e.target_index)
				report("target_index", 32'(got.target_index), 32'(e.target_index));
			if (got.status !== e.status) report("status", 32'(got.status), 32'(e.status));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 0;
	res_t res;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [15:0] cfg_data = 0;

	steer_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	timed_trajectory_tracker dut (.*);

	always #10 clk = ~clk;

	// receiver: stall pattern, long hold-off, result checks
	always @(posedge clk) begin
		if (res_valid && !res_stall && arst_n) sb.check_result(res);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res_stall <= 1;
		end else
			res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// offer one transaction and wait until it is taken; valid stays up for the next
	task send_item(cmd_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 0;
			@(posedge clk);
		end
		cmd <= t;
		cmd_valid <= 1;
		do @(posedge clk); while (cmd_stall);
		sb.note_input(t);
	endtask

	task drain();
		cmd_valid <= 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task write_gain(logic idx, logic [15:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		if (idx == REG_LONG_GAIN) sb.k_long = val; else sb.k_lat = val;
	endtask

	function cmd_t rand_item(int pct_append, int pct_pos);
		cmd_t t;
		int r;
		logic [287:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		t = raw[$bits(cmd_t)-1:0];
		r = $urandom_range(99);
		if (r < pct_append) t.command = CMD_APPEND;
		else if (r < pct_append + pct_pos) t.command = CMD_POSITION;
		else if (r < 97) t.command = CMD_CONTROL;
		else t.command = CMD_SPARE;
		// mostly modest distances, speeds and yaw rates so commands stay off the rails
		if ($urandom_range(3) != 0) begin
			t.pos_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			t.pos_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			t.wp_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			t.wp_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
			t.wp_speed = 16'($urandom_range(0, 2560));
			t.wp_yawrate = 16'($signed($urandom_range(0, 8192)) - 4096);
		end
		return t;
	endfunction

	// table of n entries with increasing time stamps, random content
	task build_track(int n);
		cmd_t t;
		logic [31:0] stamp;
		stamp = 0;
		for (int i = 0; i < n; i++) begin
			t = rand_item(100, 0);
			stamp = stamp + $urandom_range(1, 1 << 17);
			t.wp_time = stamp;
			send_item(t);
		end
	endtask

	initial begin
		cmd_t t;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, unused code, zero period, extremes
		t = '0; t.command = CMD_CONTROL; send_item(t);
		t.command = CMD_SPARE; send_item(t);
		t = '0; t.command = CMD_APPEND; send_item(t);
		t.command = CMD_CONTROL; t.elapsed_time = '1; send_item(t);
		t = '1; t.command = CMD_POSITION; send_item(t);
		t = '0; t.command = CMD_POSITION; t.pos_x = 32'sh8000_0000;
		t.pos_y = 32'sh7FFF_FFFF; send_item(t);
		t = '1; t.command = CMD_APPEND; t.wp_x = 32'sh7FFF_FFFF; send_item(t);
		t = '1; t.command = CMD_CONTROL; send_item(t);
		t = '0; t.command = CMD_CONTROL; t.pos_yaw = 16'h8000; send_item(t);
		t.pos_yaw = 16'h4000; t.elapsed_time = 32'hFFFF_FFFE; send_item(t);
		drain();
		write_gain(REG_LONG_GAIN, 16'hFFFF);
		write_gain(REG_LAT_GAIN, 16'h0000);
		t = '1; t.command = CMD_CONTROL; t.pos_yaw = 16'h3FFF; send_item(t);
		t.pos_yaw = 16'hC000; send_item(t);
		drain();
		// the table is cleared only by reset; later appends fill the rest to reach full
		write_gain(REG_LONG_GAIN, 16'd655);
		write_gain(REG_LAT_GAIN, 16'hFFFF);

		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 77 : 34) : 0;
			recv_stall_pct = (ph == 2) ? 77 : ((ph == 3) ? 34 : 0);
			if (ph == 0) hold_off = 3000;
			for (int i = 0; i < 60; i++) send_item(rand_item(15, 20));
			drain();
			write_gain(REG_LONG_GAIN, 16'($urandom));
			write_gain(REG_LAT_GAIN, 16'($urandom));
		end
		// fill the table past capacity, then steer against the long track
		send_idle_pct = 0; recv_stall_pct = 20;
		build_track(TABLE_DEPTH);
		for (int i = 0; i < 40; i++) send_item(rand_item(5, 20));
		drain();
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
